>>> rtl/core/smt_pkg.sv
package smt_pkg;

  // fixed field widths and the default table capacity
  localparam int DATA_W           = 32;
  localparam int COUNT_FIELD_W    = 7;
  localparam int DEFAULT_CAPACITY = 64;

  // beat widths on the stream ports
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_INS_SCAN,
    ST_INS_LAST,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_RESULT
  } state_t;

endpackage

>>> rtl/core/smt_ram.sv
module smt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/sorted_multiset_table.sv
// channel  | dir | beat contents
// ---------+-----+---------------------------------------------------------
// s_*      | in  | tdata: value[31:0]; tuser: opcode[0]
// m_*      | out | tdata: ok[0], entry_count[7:1], is_empty[8], zeros[15:9]
//
// one item at a time; a single ram read port and one signed comparator walk the
// table, and a finished item is held in ST_RESULT until the output register is
// free, so m_tready back-pressure stalls the sequencer there.
// insert scans down moving entries up; remove scans up to a match, then moves the tail down.
// rst clears the entry count and the sequencer; table contents need no reset.
// a new beat can be taken while the previous result still waits on m_tready.
module sorted_multiset_table #(
  parameter int CAPACITY = smt_pkg::DEFAULT_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [smt_pkg::S_TDATA_W-1:0]  s_tdata,  // value[31:0]
  input  logic [smt_pkg::S_TUSER_W-1:0]  s_tuser,  // opcode[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [smt_pkg::M_TDATA_W-1:0]  m_tdata   // ok, entry_count[6:0], is_empty, pad
);

  import smt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic              op;
  logic [DATA_W-1:0] val;
  logic [AW-1:0]     idx, idx_next;
  logic [CW-1:0]     count, count_next;
  logic              res_ok, res_ok_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic [CW:0]       idx_p1, idx_p2;
  logic              data_lt, data_eq;
  logic              is_full, is_zero, at_bottom;
  logic              out_free;

  smt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared comparator: stored entry against the operand
  assign data_lt = $signed(rd_data) < $signed(val);
  assign data_eq = rd_data == val;

  assign idx_p1    = (CW + 1)'(idx) + (CW + 1)'(1);
  assign idx_p2    = (CW + 1)'(idx) + (CW + 1)'(2);
  assign is_full   = count == CW'(CAPACITY);
  assign is_zero   = count == '0;
  assign at_bottom = idx == '0;
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready = state == ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_START;
      end
      ST_START: begin
        if (op == OP_INSERT) begin
          state_next = (is_full || is_zero) ? ST_RESULT : ST_INS_SCAN;
        end else begin
          state_next = is_zero ? ST_RESULT : ST_REM_SCAN;
        end
      end
      ST_INS_SCAN: begin
        if (data_lt) state_next = ST_RESULT;
        else if (at_bottom) state_next = ST_INS_LAST;
      end
      ST_INS_LAST: state_next = ST_RESULT;
      ST_REM_SCAN: begin
        if (data_lt) begin
          if (idx_p1 == (CW + 1)'(count)) state_next = ST_RESULT;
        end else if (data_eq) begin
          state_next = (idx_p1 == (CW + 1)'(count)) ? ST_RESULT : ST_REM_SHIFT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_REM_SHIFT: begin
        if (idx_p2 == (CW + 1)'(count)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = idx;
    wr_data     = rd_data;
    rd_addr     = idx;
    idx_next    = idx;
    count_next  = count;
    res_ok_next = res_ok;
    case (state)
      ST_START: begin
        res_ok_next = 1'b0;
        if (op == OP_INSERT) begin
          if (!is_full) begin
            if (is_zero) begin
              wr_en       = 1'b1;
              wr_addr     = '0;
              wr_data     = val;
              count_next  = count + CW'(1);
              res_ok_next = 1'b1;
            end else begin
              rd_addr  = AW'(count - CW'(1));
              idx_next = AW'(count - CW'(1));
            end
          end
        end else if (!is_zero) begin
          rd_addr  = '0;
          idx_next = '0;
        end
      end
      ST_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_p1);
        if (data_lt) begin
          wr_data     = val;
          count_next  = count + CW'(1);
          res_ok_next = 1'b1;
        end else begin
          wr_data  = rd_data;
          rd_addr  = idx - AW'(1);
          idx_next = idx - AW'(1);
        end
      end
      ST_INS_LAST: begin
        wr_en       = 1'b1;
        wr_addr     = '0;
        wr_data     = val;
        count_next  = count + CW'(1);
        res_ok_next = 1'b1;
      end
      ST_REM_SCAN: begin
        if (data_lt) begin
          if (idx_p1 != (CW + 1)'(count)) begin
            rd_addr  = AW'(idx_p1);
            idx_next = AW'(idx_p1);
          end
        end else if (data_eq) begin
          if (idx_p1 == (CW + 1)'(count)) begin
            count_next  = count - CW'(1);
            res_ok_next = 1'b1;
          end else begin
            rd_addr = AW'(idx_p1);
          end
        end
      end
      ST_REM_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (idx_p2 == (CW + 1)'(count)) begin
          count_next  = count - CW'(1);
          res_ok_next = 1'b1;
        end else begin
          rd_addr  = AW'(idx_p2);
          idx_next = AW'(idx_p1);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // operand and scan registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= s_tuser[0];
      val <= s_tdata[DATA_W-1:0];
    end
    idx    <= idx_next;
    res_ok <= res_ok_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {(M_TDATA_W - COUNT_FIELD_W - 2)'(0), is_zero,
                  COUNT_FIELD_W'(count), res_ok};
    end
  end

  // count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // writes land inside the occupied range or one past it
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW + 1)'(wr_addr) <= (CW + 1)'(count))
    else $error("table write beyond occupied range");

  // count moves only as an operation finishes
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> state == ST_RESULT)
    else $error("entry count changed mid-operation");

  // a finished insert or remove changes the count by at most one
  a_ok_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

endmodule

>>> dv/smt_checker.sv
// watches both stream channels, keeps its own sorted copy of the table and
// compares every result beat against the status predicted for it
module smt_checker #(
  parameter int CAPACITY = smt_pkg::DEFAULT_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [smt_pkg::S_TDATA_W-1:0] s_tdata,   // value[31:0]
  input  logic [smt_pkg::S_TUSER_W-1:0] s_tuser,   // opcode[0]
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [smt_pkg::M_TDATA_W-1:0] m_tdata,   // ok, entry_count[6:0], is_empty, pad
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic                              ok;
    logic [smt_pkg::COUNT_FIELD_W-1:0] entry_count;
    logic                              is_empty;
  } op_status_t;

  logic signed [smt_pkg::DATA_W-1:0] held_vals [CAPACITY];
  int                                held_count;
  op_status_t                        due_status [$];

  // apply one insert or remove to the sorted copy and return its status
  function automatic op_status_t apply_op(input logic op,
                                          input logic signed [smt_pkg::DATA_W-1:0] val);
    op_status_t st;
    int         pos;
    int         k;
    st.ok = 1'b0;
    pos   = 0;
    // first slot holding a value that is not smaller
    while (pos < held_count && held_vals[pos] < val) pos++;
    if (op == smt_pkg::OP_INSERT) begin
      if (held_count < CAPACITY) begin
        for (k = held_count; k > pos; k--) held_vals[k] = held_vals[k-1];
        held_vals[pos] = val;
        held_count++;
        st.ok = 1'b1;
      end
    end else if (pos < held_count && held_vals[pos] == val) begin
      for (k = pos; k + 1 < held_count; k++) held_vals[k] = held_vals[k+1];
      held_count--;
      st.ok = 1'b1;
    end
    st.entry_count = held_count[smt_pkg::COUNT_FIELD_W-1:0];
    st.is_empty    = (held_count == 0);
    return st;
  endfunction

  task automatic report(input string field, input int exp_v, input int act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    op_status_t exp_st;
    op_status_t act_st;
    if (rst) begin
      fail_count = 0;
      held_count = 0;
      due_status.delete();
    end else begin
      // result beat: compare against the oldest prediction first
      if (m_tvalid && m_tready) begin
        act_st.ok          = m_tdata[0];
        act_st.entry_count = m_tdata[7:1];
        act_st.is_empty    = m_tdata[8];
        if (due_status.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
        end else begin
          exp_st = due_status.pop_front();
          if (act_st.ok != exp_st.ok) report("ok", exp_st.ok, act_st.ok);
          if (act_st.entry_count != exp_st.entry_count)
            report("entry_count", exp_st.entry_count, act_st.entry_count);
          if (act_st.is_empty != exp_st.is_empty)
            report("is_empty", exp_st.is_empty, act_st.is_empty);
        end
      end
      // input beat: predict its status
      if (s_tvalid && s_tready)
        due_status.push_back(apply_op(s_tuser[0], s_tdata));
    end
    pending = due_status.size();
  end

endmodule

>>> dv/tb.sv
module tb;

  localparam int CAPACITY     = smt_pkg::DEFAULT_CAPACITY;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 385;
  localparam int HOLD_CYCLES  = 300;
  localparam int RECENT_DEPTH = 96;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [smt_pkg::S_TDATA_W-1:0] s_tdata  = '0;   // value[31:0]
  logic [smt_pkg::S_TUSER_W-1:0] s_tuser  = '0;   // opcode[0]
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [smt_pkg::M_TDATA_W-1:0] m_tdata;         // ok, entry_count[6:0], is_empty, pad

  int   fail_count;
  int   pending;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_off     = 1'b0;

  logic [31:0] recent_inserts [$];

  sorted_multiset_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  smt_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side backpressure
  always @(posedge clk) begin
    m_tready <= !hold_off && ($urandom_range(99) >= rx_stall_pct);
  end

  // one long hold-off on the result side so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one beat, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [31:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    if (op == smt_pkg::OP_INSERT) begin
      recent_inserts.push_back(val);
      if (recent_inserts.size() > RECENT_DEPTH) void'(recent_inserts.pop_front());
    end
  endtask

  // small values give duplicates, extremes hit the ordering corners
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 32'($signed($urandom_range(6)) - 3);
    if (sel < 60) begin
      case ($urandom_range(5))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h8000_0001;
        3:       return 32'h7fff_fffe;
        4:       return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  // removes mostly target something inserted recently
  function automatic logic [31:0] pick_remove_value();
    if (recent_inserts.size() != 0 && $urandom_range(99) < 70)
      return recent_inserts[$urandom_range(recent_inserts.size() - 1)];
    return pick_value();
  endfunction

  initial begin
    int   phase;
    int   n;
    int   burst_left;
    int   insert_pct;
    logic op;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty removes, extremes, duplicates, absent values, drain to empty
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0000);
    send_item(smt_pkg::OP_INSERT, 32'h7fff_ffff);
    send_item(smt_pkg::OP_INSERT, 32'h8000_0000);
    send_item(smt_pkg::OP_INSERT, 32'h0000_0000);
    send_item(smt_pkg::OP_INSERT, 32'h0000_0000);
    send_item(smt_pkg::OP_INSERT, 32'hffff_ffff);
    send_item(smt_pkg::OP_INSERT, 32'h0000_0001);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0005);
    send_item(smt_pkg::OP_REMOVE, 32'h7fff_fffe);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0000);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0000);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0000);
    send_item(smt_pkg::OP_REMOVE, 32'h8000_0000);
    send_item(smt_pkg::OP_REMOVE, 32'h7fff_ffff);
    send_item(smt_pkg::OP_REMOVE, 32'hffff_ffff);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0001);
    send_item(smt_pkg::OP_REMOVE, 32'h0000_0001);

    // random: fill-heavy and drain-heavy bursts reach both full and empty
    burst_left = 0;
    insert_pct = 50;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 46; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 46; end
        default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 30) hold_req = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(70, 120);
          case ($urandom_range(9))
            0:       insert_pct = 50;
            1, 2, 3, 4: insert_pct = 90;
            default: insert_pct = 10;
          endcase
        end
        burst_left--;
        op = ($urandom_range(99) < insert_pct) ? smt_pkg::OP_INSERT : smt_pkg::OP_REMOVE;
        if (op == smt_pkg::OP_INSERT) send_item(op, pick_value());
        else                          send_item(op, pick_remove_value());
      end
    end
    s_tvalid <= 1'b0;

    // drain, then let any stray beat show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
